@@ rtl/core/icmp_pkg.sv @@
// Package for the ICMP echo reply parser: payload structs, result kinds,
// byte positions and protocol constants. No dependencies.
package icmp_pkg;

    localparam int MAX_PACKET = 2047;
    localparam int CNT_W      = $clog2(MAX_PACKET + 1);
    localparam int LEN_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_ID      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_OTHER = CFG_IDX_W'(1);

    localparam logic [CNT_W-1:0] POS_VER_IHL = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_TTL     = CNT_W'(8);
    localparam logic [CNT_W-1:0] POS_PROTO   = CNT_W'(9);

    localparam logic [CNT_W-1:0] OFF_TYPE    = CNT_W'(0);
    localparam logic [CNT_W-1:0] OFF_CODE    = CNT_W'(1);
    localparam logic [CNT_W-1:0] OFF_ID_LO   = CNT_W'(4);
    localparam logic [CNT_W-1:0] OFF_ID_HI   = CNT_W'(5);
    localparam logic [CNT_W-1:0] OFF_SEQ_LO  = CNT_W'(6);
    localparam logic [CNT_W-1:0] OFF_SEQ_HI  = CNT_W'(7);
    localparam logic [CNT_W-1:0] OFF_SEC_LO  = CNT_W'(8);
    localparam logic [CNT_W-1:0] OFF_SEC_HI  = CNT_W'(11);
    localparam logic [CNT_W-1:0] OFF_USEC_LO = CNT_W'(12);
    localparam logic [CNT_W-1:0] OFF_USEC_HI = CNT_W'(15);

    localparam logic [7:0]       PROTO_ICMP      = 8'd1;
    localparam logic [7:0]       ICMP_ECHO_REPLY = 8'd0;
    localparam logic [CNT_W-1:0] MIN_IP_LEN      = CNT_W'(20);
    localparam logic [CNT_W-1:0] ICMP_HDR_LEN    = CNT_W'(8);
    localparam logic [CNT_W-1:0] ICMP_ECHO_LEN   = CNT_W'(16);
    localparam logic [19:0]      USEC_PER_SEC    = 20'd1000000;

    typedef enum logic [1:0] {
        KIND_DROP  = 2'd0,
        KIND_ECHO  = 2'd1,
        KIND_OTHER = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0]         data_byte;
        logic               last_byte;
        logic signed [31:0] recv_sec;
        logic [19:0]        recv_usec;
    } t_in;

    typedef struct packed {
        t_kind              kind;
        logic [LEN_W-1:0]   icmp_len;
        logic [7:0]         msg_type;
        logic [7:0]         msg_code;
        logic [15:0]        seq;
        logic [7:0]         ttl;
        logic signed [31:0] rtt_sec;
        logic [19:0]        rtt_usec;
    } t_out;

    typedef struct packed {
        logic [15:0] echo_id;
        logic        report_other;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0] byte_count;
        logic [5:0]       hdr_len;
        logic [7:0]       protocol;
        logic [7:0]       ttl;
        logic [7:0]       msg_type;
        logic [7:0]       msg_code;
        logic [15:0]      id;
        logic [15:0]      seq;
        logic [31:0]      send_sec;
        logic [31:0]      send_usec;
    } t_pkt;

    typedef struct packed {
        t_kind            kind;
        logic [LEN_W-1:0] icmp_len;
        logic [7:0]       msg_type;
        logic [7:0]       msg_code;
        logic [15:0]      seq;
        logic [7:0]       ttl;
        logic [31:0]      send_sec;
        logic [31:0]      send_usec;
        logic [31:0]      recv_sec;
        logic [19:0]      recv_usec;
    } t_job;

endpackage

@@ rtl/core/icmp_front.sv @@
// Front end: captures header and ICMP fields byte by byte and classifies
// each packet on its last byte. Depends on icmp_pkg.
module icmp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  icmp_pkg::t_in  i_data,
    input  icmp_pkg::t_cfg i_cfg,
    output logic           o_job_valid,
    input  logic           i_job_ready,
    output icmp_pkg::t_job o_job
);

    icmp_pkg::t_pkt r_pkt;
    icmp_pkg::t_pkt n_pkt;
    icmp_pkg::t_pkt c_pkt;

    logic                       accept;
    logic [icmp_pkg::CNT_W-1:0] pos;
    logic [icmp_pkg::CNT_W-1:0] off;
    logic [icmp_pkg::CNT_W-1:0] hl;
    logic [icmp_pkg::CNT_W-1:0] len;
    logic [icmp_pkg::CNT_W-1:0] ilen;
    logic                       icmp_ok;
    icmp_pkg::t_kind            kind;

    assign o_ready     = i_job_ready;
    assign accept      = i_valid && o_ready;
    assign o_job_valid = i_valid && i_data.last_byte;

    always_comb begin
        c_pkt = r_pkt;
        pos   = r_pkt.byte_count;
        off   = '0;
        if (accept && (r_pkt.byte_count < icmp_pkg::CNT_W'(icmp_pkg::MAX_PACKET))) begin
            if (pos == icmp_pkg::POS_VER_IHL) c_pkt.hdr_len = {i_data.data_byte[3:0], 2'b00};
            if (pos == icmp_pkg::POS_TTL)     c_pkt.ttl = i_data.data_byte;
            if (pos == icmp_pkg::POS_PROTO)   c_pkt.protocol = i_data.data_byte;
            if (pos >= icmp_pkg::CNT_W'(c_pkt.hdr_len)) begin
                off = pos - icmp_pkg::CNT_W'(c_pkt.hdr_len);
                case (off)
                    icmp_pkg::OFF_TYPE:   c_pkt.msg_type = i_data.data_byte;
                    icmp_pkg::OFF_CODE:   c_pkt.msg_code = i_data.data_byte;
                    icmp_pkg::OFF_ID_LO:  c_pkt.id[7:0] = i_data.data_byte;
                    icmp_pkg::OFF_ID_HI:  c_pkt.id[15:8] = i_data.data_byte;
                    icmp_pkg::OFF_SEQ_LO: c_pkt.seq[7:0] = i_data.data_byte;
                    icmp_pkg::OFF_SEQ_HI: c_pkt.seq[15:8] = i_data.data_byte;
                    default: begin
                        if (off inside {[icmp_pkg::OFF_SEC_LO:icmp_pkg::OFF_SEC_HI]}) begin
                            c_pkt.send_sec[{off[1:0], 3'b000} +: 8] = i_data.data_byte;
                        end else if (off inside
                                {[icmp_pkg::OFF_USEC_LO:icmp_pkg::OFF_USEC_HI]}) begin
                            c_pkt.send_usec[{off[1:0], 3'b000} +: 8] = i_data.data_byte;
                        end
                    end
                endcase
            end
            c_pkt.byte_count = r_pkt.byte_count + 1'b1;
        end

        len     = c_pkt.byte_count;
        hl      = icmp_pkg::CNT_W'(c_pkt.hdr_len);
        ilen    = len - hl;
        icmp_ok = (c_pkt.protocol == icmp_pkg::PROTO_ICMP) && (len >= icmp_pkg::MIN_IP_LEN)
                  && (len >= hl + icmp_pkg::ICMP_HDR_LEN);
        kind    = icmp_pkg::KIND_DROP;
        if (icmp_ok) begin
            if (c_pkt.msg_type == icmp_pkg::ICMP_ECHO_REPLY) begin
                if ((c_pkt.id == i_cfg.echo_id) && (ilen >= icmp_pkg::ICMP_ECHO_LEN)) begin
                    kind = icmp_pkg::KIND_ECHO;
                end
            end else if (i_cfg.report_other) begin
                kind = icmp_pkg::KIND_OTHER;
            end
        end

        o_job.kind      = kind;
        o_job.icmp_len  = icmp_pkg::LEN_W'(ilen);
        o_job.msg_type  = c_pkt.msg_type;
        o_job.msg_code  = c_pkt.msg_code;
        o_job.seq       = c_pkt.seq;
        o_job.ttl       = c_pkt.ttl;
        o_job.send_sec  = c_pkt.send_sec;
        o_job.send_usec = c_pkt.send_usec;
        o_job.recv_sec  = i_data.recv_sec;
        o_job.recv_usec = i_data.recv_usec;

        n_pkt = (accept && i_data.last_byte) ? '0 : c_pkt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt <= '0;
        end else begin
            r_pkt <= n_pkt;
        end
    end

endmodule

@@ rtl/core/icmp_queue.sv @@
// Two-entry request queue between the front end and the back end.
// Depends on icmp_pkg.
module icmp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  icmp_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output icmp_pkg::t_job o_job
);

    icmp_pkg::t_job r_head;
    icmp_pkg::t_job r_tail;
    logic           r_head_v;
    logic           r_tail_v;
    logic           push;
    logic           pop;

    assign o_ready = !r_tail_v;
    assign o_valid = r_head_v;
    assign o_job   = r_head;
    assign push    = i_valid && o_ready;
    assign pop     = r_head_v && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v <= 1'b0;
            r_tail_v <= 1'b0;
        end else if (pop) begin
            if (r_tail_v) begin
                r_tail_v <= 1'b0;
            end else begin
                r_head_v <= push;
            end
        end else if (push) begin
            if (r_head_v) begin
                r_tail_v <= 1'b1;
            end else begin
                r_head_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_tail_v) begin
                r_head <= r_tail;
            end else if (push) begin
                r_head <= i_job;
            end
        end else if (push) begin
            if (r_head_v) begin
                r_tail <= i_job;
            end else begin
                r_head <= i_job;
            end
        end
    end

endmodule

@@ rtl/core/icmp_back.sv @@
// Back end: computes round-trip time with microsecond borrow, masks fields
// by result kind and holds the result register. Depends on icmp_pkg.
module icmp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  icmp_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output icmp_pkg::t_out o_data
);

    icmp_pkg::t_out     r_out;
    icmp_pkg::t_out     n_out;
    logic               r_out_v;
    logic signed [33:0] usec_diff;
    logic               borrow;
    logic [19:0]        rtt_usec;
    logic [31:0]        rtt_sec;

    assign o_ready = !r_out_v || i_ready;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    always_comb begin
        usec_diff = $signed({14'd0, i_job.recv_usec})
                    - $signed({{2{i_job.send_usec[31]}}, i_job.send_usec});
        borrow    = usec_diff[33];
        rtt_usec  = usec_diff[19:0] + (borrow ? icmp_pkg::USEC_PER_SEC : 20'd0);
        rtt_sec   = i_job.recv_sec - i_job.send_sec - {31'd0, borrow};

        n_out = '0;
        case (i_job.kind)
            icmp_pkg::KIND_ECHO: begin
                n_out.kind      = icmp_pkg::KIND_ECHO;
                n_out.icmp_len  = i_job.icmp_len;
                n_out.msg_type  = i_job.msg_type;
                n_out.msg_code  = i_job.msg_code;
                n_out.seq       = i_job.seq;
                n_out.ttl       = i_job.ttl;
                n_out.rtt_sec   = $signed(rtt_sec);
                n_out.rtt_usec  = rtt_usec;
            end
            icmp_pkg::KIND_OTHER: begin
                n_out.kind      = icmp_pkg::KIND_OTHER;
                n_out.icmp_len  = i_job.icmp_len;
                n_out.msg_type  = i_job.msg_type;
                n_out.msg_code  = i_job.msg_code;
            end
            default: n_out = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (o_ready) begin
            r_out_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_out <= n_out;
        end
    end

endmodule

@@ rtl/core/icmp_echo_reply_parser.sv @@
// ICMP echo reply parser top level; depends on icmp_pkg, icmp_front, icmp_queue, icmp_back.
// Throughput: one packet byte per cycle while the request queue has a free entry.
// Result path: after the last byte is accepted, the job passes the queue register, then
// the round-trip subtract into the result register.
// Reset: synchronous, active low; clears packet state, queue and result valid;
// echo_id resets to 0 and report_other to 1.
module icmp_echo_reply_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  icmp_pkg::t_in                       i_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output icmp_pkg::t_out                      o_data,
    input  logic                                i_cfg_we,
    input  logic [icmp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [icmp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    icmp_pkg::t_cfg r_cfg;
    icmp_pkg::t_job front_job;
    icmp_pkg::t_job back_job;
    logic           front_valid;
    logic           front_ready;
    logic           back_valid;
    logic           back_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.echo_id      <= 16'd0;
            r_cfg.report_other <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                icmp_pkg::CFG_ECHO_ID:      r_cfg.echo_id <= i_cfg_data[15:0];
                icmp_pkg::CFG_REPORT_OTHER: r_cfg.report_other <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    icmp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .i_cfg       (r_cfg),
        .o_job_valid (front_valid),
        .i_job_ready (front_ready),
        .o_job       (front_job)
    );

    icmp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_job   (front_job),
        .o_valid (back_valid),
        .i_ready (back_ready),
        .o_job   (back_job)
    );

    icmp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (back_valid),
        .o_ready (back_ready),
        .i_job   (back_job),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

`ifndef SYNTHESIS
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.kind == icmp_pkg::KIND_DROP) |->
            (o_data.icmp_len == '0) && (o_data.msg_type == 8'd0) && (o_data.seq == 16'd0)
            && (o_data.rtt_sec == 32'sd0) && (o_data.rtt_usec == 20'd0))
        else $error("dropped packet carries nonzero fields");

    a_other_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.kind == icmp_pkg::KIND_OTHER) |->
            (o_data.seq == 16'd0) && (o_data.ttl == 8'd0) && (o_data.rtt_sec == 32'sd0)
            && (o_data.rtt_usec == 20'd0) && (o_data.msg_type != icmp_pkg::ICMP_ECHO_REPLY))
        else $error("other ICMP result not masked");

    a_echo_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.kind == icmp_pkg::KIND_ECHO) |->
            (o_data.msg_type == icmp_pkg::ICMP_ECHO_REPLY)
            && (o_data.icmp_len >= icmp_pkg::LEN_W'(16)))
        else $error("echo reply result with bad type or length");
`endif

endmodule

@@ bench/icmp_echo_reply_parser_test.sv @@
`timescale 1ns / 1ps
// Testbench for icmp_echo_reply_parser: random IPv4/ICMP packets fed byte by byte,
// results checked against a packet-level predictor. Depends on icmp_pkg and the RTL.
module icmp_echo_reply_parser_test;

    class reply_predictor;
        logic [15:0]                echo_id;
        logic                       report_other;
        logic [icmp_pkg::CNT_W-1:0] count;
        logic [5:0]                 hdr_len;
        logic [7:0]                 proto;
        logic [7:0]                 ttl;
        logic [7:0]                 msg_type;
        logic [7:0]                 msg_code;
        logic [15:0]                id;
        logic [15:0]                seq;
        logic [31:0]                send_sec;
        logic [31:0]                send_usec;
        icmp_pkg::t_out             expected_replies[$];
        int                         errors;

        function new();
            echo_id      = '0;
            report_other = 1'b1;
            errors       = 0;
            clear();
        endfunction

        function void clear();
            count     = '0;
            hdr_len   = '0;
            proto     = '0;
            ttl       = '0;
            msg_type  = '0;
            msg_code  = '0;
            id        = '0;
            seq       = '0;
            send_sec  = '0;
            send_usec = '0;
        endfunction

        function void take_byte(icmp_pkg::t_in req);
            int             pos;
            int             off;
            int             len;
            int             ilen;
            longint         diff;
            logic [31:0]    sec;
            logic [7:0]     b;
            icmp_pkg::t_out r;
            b = req.data_byte;
            if (count < icmp_pkg::MAX_PACKET) begin
                pos = int'(count);
                if (pos == icmp_pkg::POS_VER_IHL) hdr_len = {b[3:0], 2'b00};
                if (pos == icmp_pkg::POS_TTL) ttl = b;
                if (pos == icmp_pkg::POS_PROTO) proto = b;
                if (pos >= hdr_len) begin
                    off = pos - hdr_len;
                    if (off == icmp_pkg::OFF_TYPE) msg_type = b;
                    else if (off == icmp_pkg::OFF_CODE) msg_code = b;
                    else if (off == icmp_pkg::OFF_ID_LO || off == icmp_pkg::OFF_ID_HI)
                        id[8 * (off - icmp_pkg::OFF_ID_LO) +: 8] = b;
                    else if (off == icmp_pkg::OFF_SEQ_LO || off == icmp_pkg::OFF_SEQ_HI)
                        seq[8 * (off - icmp_pkg::OFF_SEQ_LO) +: 8] = b;
                    else if (off >= icmp_pkg::OFF_SEC_LO && off <= icmp_pkg::OFF_SEC_HI)
                        send_sec[8 * (off - icmp_pkg::OFF_SEC_LO) +: 8] = b;
                    else if (off >= icmp_pkg::OFF_USEC_LO && off <= icmp_pkg::OFF_USEC_HI)
                        send_usec[8 * (off - icmp_pkg::OFF_USEC_LO) +: 8] = b;
                end
                count = count + 1'b1;
            end
            if (!req.last_byte) return;
            r    = '0;
            len  = int'(count);
            ilen = len - hdr_len;
            if (proto == icmp_pkg::PROTO_ICMP && len >= icmp_pkg::MIN_IP_LEN
                    && len >= hdr_len + icmp_pkg::ICMP_HDR_LEN) begin
                if (msg_type == icmp_pkg::ICMP_ECHO_REPLY) begin
                    if (id == echo_id && ilen >= icmp_pkg::ICMP_ECHO_LEN) begin
                        diff = longint'(req.recv_usec) - longint'($signed(send_usec));
                        sec  = req.recv_sec - send_sec;
                        if (diff < 0) begin
                            diff = diff + longint'(icmp_pkg::USEC_PER_SEC);
                            sec  = sec - 32'd1;
                        end
                        r.kind      = icmp_pkg::KIND_ECHO;
                        r.icmp_len  = icmp_pkg::LEN_W'(ilen);
                        r.msg_type  = msg_type;
                        r.msg_code  = msg_code;
                        r.seq       = seq;
                        r.ttl       = ttl;
                        r.rtt_sec   = sec;
                        r.rtt_usec  = diff[19:0];
                    end
                end else if (report_other) begin
                    r.kind      = icmp_pkg::KIND_OTHER;
                    r.icmp_len  = icmp_pkg::LEN_W'(ilen);
                    r.msg_type  = msg_type;
                    r.msg_code  = msg_code;
                end
            end
            expected_replies.push_back(r);
            clear();
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_reply(icmp_pkg::t_out got);
            icmp_pkg::t_out want;
            if (expected_replies.size() == 0) begin
                $error("result with no packet pending: kind %0d", got.kind);
                errors++;
                return;
            end
            want = expected_replies.pop_front();
            compare("kind", 32'(want.kind), 32'(got.kind));
            compare("icmp_len", 32'(want.icmp_len), 32'(got.icmp_len));
            compare("msg_type", 32'(want.msg_type), 32'(got.msg_type));
            compare("msg_code", 32'(want.msg_code), 32'(got.msg_code));
            compare("seq", 32'(want.seq), 32'(got.seq));
            compare("ttl", 32'(want.ttl), 32'(got.ttl));
            compare("rtt_sec", want.rtt_sec, got.rtt_sec);
            compare("rtt_usec", 32'(want.rtt_usec), 32'(got.rtt_usec));
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_ready;
    icmp_pkg::t_in                   i_data;
    logic                            o_valid;
    logic                            i_ready;
    icmp_pkg::t_out                  o_data;
    logic                            i_cfg_we;
    logic [icmp_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [icmp_pkg::CFG_DATA_W-1:0] i_cfg_data;

    reply_predictor replies;
    logic [7:0]     frame[$];
    bit             quiet;
    int             hold_off;
    int             bytes_sent;

    icmp_echo_reply_parser u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    task automatic send_item(input icmp_pkg::t_in req);
        int n;
        n = quiet ? 0 : $urandom_range(0, 5);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        replies.take_byte(req);
        bytes_sent++;
    endtask

    task automatic build_frame(input int len, input logic [3:0] ihl, input logic [7:0] proto,
                               input logic [7:0] ttl, input logic [7:0] msg_type,
                               input logic [7:0] msg_code, input logic [15:0] id,
                               input logic [15:0] seq, input logic [31:0] ssec,
                               input logic [31:0] susec);
        logic [7:0] icmp_hdr[16];
        int         h;
        frame.delete();
        repeat (len) frame.push_back(8'($urandom));
        h = 4 * ihl;
        icmp_hdr = '{msg_type, msg_code, 8'($urandom), 8'($urandom),
                     id[7:0], id[15:8], seq[7:0], seq[15:8],
                     ssec[7:0], ssec[15:8], ssec[23:16], ssec[31:24],
                     susec[7:0], susec[15:8], susec[23:16], susec[31:24]};
        frame[0] = {4'h4, ihl};
        if (len > 8) frame[8] = ttl;
        if (len > 9) frame[9] = proto;
        for (int k = 0; k < 16; k++) begin
            if (h + k < len) frame[h + k] = icmp_hdr[k];
        end
    endtask

    task automatic send_frame(input logic [31:0] rsec, input logic [19:0] rusec);
        icmp_pkg::t_in req;
        foreach (frame[i]) begin
            req.data_byte = frame[i];
            req.last_byte = (i == frame.size() - 1);
            req.recv_sec  = req.last_byte ? rsec : $urandom;
            req.recv_usec = req.last_byte ? rusec : 20'($urandom_range(0, 999999));
            send_item(req);
        end
    endtask

    task automatic random_packet();
        int          sel;
        int          h;
        logic [3:0]  ihl;
        logic [31:0] susec;
        logic [15:0] id;
        logic [7:0]  other_type;
        sel        = $urandom_range(0, 99);
        ihl        = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
        h          = 4 * ihl;
        susec      = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 999999);
        id         = ($urandom_range(0, 9) == 0) ? 16'($urandom) : replies.echo_id;
        other_type = 8'($urandom_range(1, 255));
        if (sel < 55) begin
            build_frame(h + 16 + $urandom_range(0, 24), ihl, icmp_pkg::PROTO_ICMP,
                        8'($urandom), icmp_pkg::ICMP_ECHO_REPLY, 8'($urandom), id,
                        16'($urandom), $urandom, susec);
        end else if (sel < 70) begin
            build_frame(h + 8 + $urandom_range(0, 24), ihl, icmp_pkg::PROTO_ICMP,
                        8'($urandom), other_type, 8'($urandom), id, 16'($urandom),
                        $urandom, susec);
        end else if (sel < 78) begin
            build_frame(h + 16 + $urandom_range(0, 8), ihl, 8'($urandom), 8'($urandom),
                        icmp_pkg::ICMP_ECHO_REPLY, 8'($urandom), id, 16'($urandom),
                        $urandom, susec);
        end else if (sel < 88) begin
            build_frame($urandom_range(1, h + 17), ihl, icmp_pkg::PROTO_ICMP, 8'($urandom),
                        ($urandom_range(0, 1) == 0) ? icmp_pkg::ICMP_ECHO_REPLY : other_type,
                        8'($urandom), id, 16'($urandom), $urandom, susec);
        end else if (sel < 94) begin
            ihl = 4'($urandom_range(0, 4));
            build_frame(4 * ihl + 16 + $urandom_range(0, 12), ihl, icmp_pkg::PROTO_ICMP,
                        8'($urandom), icmp_pkg::ICMP_ECHO_REPLY, 8'($urandom), id,
                        16'($urandom), $urandom, susec);
        end else begin
            build_frame($urandom_range(1, 60), ihl, 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), id, 16'($urandom), $urandom, susec);
            foreach (frame[i]) frame[i] = 8'($urandom);
        end
        send_frame($urandom, 20'($urandom_range(0, 999999)));
    endtask

    task automatic settle(input int extra);
        i_valid <= 1'b0;
        while (replies.expected_replies.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [15:0] id, input logic other);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= icmp_pkg::CFG_ECHO_ID;
        i_cfg_data <= id;
        @(posedge i_clk);
        i_cfg_idx  <= icmp_pkg::CFG_REPORT_OTHER;
        i_cfg_data <= icmp_pkg::CFG_DATA_W'(other);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        replies.echo_id      = id;
        replies.report_other = other;
        @(posedge i_clk);
    endtask

    task automatic directed_packets();
        build_frame(1, 5, icmp_pkg::PROTO_ICMP, 64, icmp_pkg::ICMP_ECHO_REPLY, 0, 0, 0, 0, 0);
        send_frame(0, 0);
        build_frame(36, 5, icmp_pkg::PROTO_ICMP, 0, icmp_pkg::ICMP_ECHO_REPLY, 0, 0, 0, 0, 0);
        send_frame(0, 0);
        build_frame(36, 5, icmp_pkg::PROTO_ICMP, 255, icmp_pkg::ICMP_ECHO_REPLY, 255, 0,
                    16'hFFFF, 32'h8000_0000, 999999);
        send_frame(32'h7FFF_FFFF, 0);
        build_frame(36, 5, icmp_pkg::PROTO_ICMP, 64, icmp_pkg::ICMP_ECHO_REPLY, 0, 16'h1234,
                    7, 5, 5);
        send_frame(9, 9);
        build_frame(35, 5, icmp_pkg::PROTO_ICMP, 64, icmp_pkg::ICMP_ECHO_REPLY, 0, 0, 7, 5, 5);
        send_frame(9, 9);
        build_frame(28, 5, icmp_pkg::PROTO_ICMP, 64, 8'd8, 0, 0, 1, 2, 3);
        send_frame(9, 9);
        build_frame(19, 5, icmp_pkg::PROTO_ICMP, 64, 8'd8, 0, 0, 1, 2, 3);
        send_frame(9, 9);
        build_frame(20, 3, icmp_pkg::PROTO_ICMP, 64, 8'd3, 1, 0, 1, 2, 3);
        send_frame(9, 9);
        build_frame(40, 5, 8'd6, 64, icmp_pkg::ICMP_ECHO_REPLY, 0, 0, 1, 2, 3);
        send_frame(9, 9);
        build_frame(70, 15, icmp_pkg::PROTO_ICMP, 64, 8'd11, 0, 0, 1, 2, 3);
        send_frame(9, 9);
        build_frame(40, 15, icmp_pkg::PROTO_ICMP, 64, icmp_pkg::ICMP_ECHO_REPLY, 0, 0, 1, 2, 3);
        send_frame(9, 9);
        build_frame(30, 0, icmp_pkg::PROTO_ICMP, 64, icmp_pkg::ICMP_ECHO_REPLY, 0, 0, 3,
                    32'h0000_0100, 4);
        send_frame(32'h8000_0000, 999999);
        build_frame(40, 5, icmp_pkg::PROTO_ICMP, 64, icmp_pkg::ICMP_ECHO_REPLY, 0, 0, 3, 100,
                    32'hFFFF_FFFF);
        send_frame(-1, 999999);
        build_frame(40, 5, icmp_pkg::PROTO_ICMP, 64, icmp_pkg::ICMP_ECHO_REPLY, 0, 0, 3, 100, 0);
        send_frame(100, 999999);
        build_frame(76, 15, icmp_pkg::PROTO_ICMP, 1, icmp_pkg::ICMP_ECHO_REPLY, 0, 0, 0, 0,
                    32'h7FFF_FFFF);
        send_frame(0, 0);
    endtask

    initial begin : drain
        int n;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            n = quiet ? 0 : $urandom_range(0, 5);
            if (hold_off > 0) begin
                n        = hold_off;
                hold_off = 0;
            end
            if (n > 0) begin
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            replies.check_reply(o_data);
        end
    end

    initial begin
        replies    = new();
        quiet      = 1'b0;
        hold_off   = 0;
        bytes_sent = 0;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_data     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        directed_packets();
        for (int p = 0; p < 5; p++) begin
            settle(4);
            case (p)
                0: write_regs(16'hFFFF, 1'b0);
                1: write_regs(16'($urandom), 1'b1);
                2: write_regs(16'h0000, 1'b1);
                3: write_regs(16'($urandom), 1'b0);
                default: write_regs(16'($urandom), 1'b1);
            endcase
            quiet = (p == 2 || p == 3);
            if (p == 3) hold_off = 300;
            if (p == 4) begin
                build_frame(icmp_pkg::MAX_PACKET + 3, 5, icmp_pkg::PROTO_ICMP, 8'($urandom),
                            icmp_pkg::ICMP_ECHO_REPLY, 8'($urandom), replies.echo_id,
                            16'($urandom), $urandom, $urandom_range(0, 999999));
                send_frame($urandom, 20'($urandom_range(0, 999999)));
            end
            bytes_sent = 0;
            while (bytes_sent < 350) random_packet();
        end
        settle(10);
        if (replies.errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule

@@ files.f @@
rtl/core/icmp_pkg.sv
rtl/core/icmp_front.sv
rtl/core/icmp_queue.sv
rtl/core/icmp_back.sv
rtl/core/icmp_echo_reply_parser.sv
bench/icmp_echo_reply_parser_test.sv
